// ----- hdl/iptc_pkg.sv -----
// Package for the inverted page table clock core: widths, codes, entry type.
// No dependencies.
package iptc_pkg;
	localparam int FRAMES = 256;
	localparam int PAGE_SHIFT = 12;
	localparam int IDX_W = $clog2(FRAMES);
	localparam int SIZE_W = IDX_W + 1;

	localparam logic [1:0] CMD_XLATE = 2'd0;
	localparam logic [1:0] CMD_RELEASE = 2'd1;
	localparam logic [1:0] CMD_FREE = 2'd2;
	localparam logic [1:0] CMD_NONE = 2'd3;

	localparam logic [2:0] ST_HIT = 3'd0;
	localparam logic [2:0] ST_LOAD_FREE = 3'd1;
	localparam logic [2:0] ST_LOAD_EVICT = 3'd2;
	localparam logic [2:0] ST_NO_FRAME = 3'd3;
	localparam logic [2:0] ST_RELEASED = 3'd4;
	localparam logic [2:0] ST_NOT_FOUND = 3'd5;
	localparam logic [2:0] ST_FREED = 3'd6;

	localparam logic CFG_BASE = 1'b0;
	localparam logic CFG_SIZE = 1'b1;

	typedef struct packed {
		logic        fref;
		logic        ftlb;
		logic        fvalid;
		logic [9:0]  pid;
		logic [19:0] vpage;
	} entry_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] paddr;
		logic [7:0]  frame;
		logic        load_request;
		logic        evict_valid;
		logic [19:0] evict_vpage;
		logic [9:0]  evict_pid;
		logic        tlb_flag_missing;
		logic [8:0]  freed_count;
	} result_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		entry_t           wdata;
		logic [IDX_W-1:0] raddr;
	} mem_ctl_t;
endpackage

// ----- hdl/iptc_table_ram.sv -----
// Entry store: one synchronous RAM, one write and one registered read a cycle.
// Depends on iptc_pkg. Cleared by a sweep from the sequencer after reset.
module iptc_table_ram import iptc_pkg::*; (
	input  logic     clk,
	input  mem_ctl_t ctl,
	output entry_t   rdata
);
	entry_t mem [FRAMES];

	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem[ctl.waddr] <= ctl.wdata;
		end
		// write-first: a read of the entry being written returns the new data
		rdata <= (ctl.we && ctl.waddr == ctl.raddr) ? ctl.wdata : mem[ctl.raddr];
	end
endmodule

// ----- hdl/iptc_seq.sv -----
// Sequencer: walks the entry RAM for lookup, free, free-slot and clock passes.
// Depends on iptc_pkg and drives iptc_table_ram through mem_ctl_t.
module iptc_seq import iptc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [1:0]  cmd,
	input  logic [19:0] vpage,
	input  logic [9:0]  pid,
	input  logic [31:0] base_paddr,
	input  logic [8:0]  table_size,
	input  entry_t      rdata,
	output mem_ctl_t    ctl,
	output logic        busy,
	output logic        done,
	output result_t     res
);
	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_LOOK, S_FREE, S_SLOT, S_CLOCK, S_DONE
	} state_t;

	state_t state_q;
	logic [SIZE_W-1:0] size_q, cnt_q;
	logic [IDX_W-1:0] pos_q, hand_q, slot_q;
	logic slot_ok_q, rd_v_q;
	logic [1:0] cmd_q;
	logic [19:0] vp_q;
	logic [9:0] pid_q;
	logic [SIZE_W+1:0] steps_q;
	result_t res_q;
	logic [IDX_W-1:0] rd_idx_q;
	logic [SIZE_W-1:0] used;
	mem_ctl_t ctl_d;

	always_comb begin
		used = table_size;
		if (table_size == '0) used = SIZE_W'(1);
		if (table_size > SIZE_W'(FRAMES)) used = SIZE_W'(FRAMES);
	end

	function automatic logic [31:0] faddr(input logic [31:0] b, input logic [IDX_W-1:0] i);
		faddr = b + (32'(i) << PAGE_SHIFT);
	endfunction

	function automatic logic [IDX_W-1:0] nxt(input logic [IDX_W-1:0] p,
			input logic [SIZE_W-1:0] s);
		nxt = (SIZE_W'(p) + SIZE_W'(1) >= s) ? '0 : p + IDX_W'(1);
	endfunction

	entry_t newe;
	assign newe = '{fref: 1'b0, ftlb: 1'b1, fvalid: 1'b1, pid: pid_q, vpage: vp_q};

	logic match;
	assign match = rdata.fvalid && rdata.pid == pid_q && rdata.vpage == vp_q;

	logic free_hit, last, victim, clk_exhausted, to_clock;
	logic [IDX_W-1:0] start_pos, pos_nx;
	assign free_hit = rdata.fvalid && rdata.pid == pid_q;
	assign last = SIZE_W'(pos_q) + SIZE_W'(1) >= size_q;
	assign victim = !rdata.ftlb && !rdata.fref;
	assign clk_exhausted = steps_q >= (SIZE_W+2)'(3) * (SIZE_W+2)'(size_q);
	assign start_pos = (SIZE_W'(hand_q) < size_q) ? hand_q : '0;
	assign pos_nx = nxt(pos_q, size_q);
	assign to_clock = state_q == S_LOOK && rd_v_q && !match && last &&
		cmd_q == CMD_XLATE && !slot_ok_q && rdata.fvalid;

	assign busy = state_q != S_IDLE;
	assign done = state_q == S_DONE;
	assign res = res_q;

	// RAM requests for the next cycle, registered into ctl; read data then passes the
	// RAM's registered read, so rd_v_q marks the cycles where rdata belongs to pos_q.
	always_comb begin
		ctl_d.we = 1'b0;
		ctl_d.waddr = pos_q;
		ctl_d.wdata = '0;
		ctl_d.raddr = ctl.raddr;
		case (state_q)
			S_CLEAR: begin
				ctl_d.we = 1'b1;
			end
			S_IDLE: begin
				if (start) ctl_d.raddr = '0;
			end
			S_LOOK, S_FREE: begin
				if (SIZE_W'(rd_idx_q) + SIZE_W'(1) < size_q) begin
					ctl_d.raddr = rd_idx_q + IDX_W'(1);
				end
				if (rd_v_q) begin
					if (state_q == S_FREE) begin
						ctl_d.we = free_hit;
					end else if (match) begin
						ctl_d.we = 1'b1;
						ctl_d.wdata = rdata;
						ctl_d.wdata.ftlb = cmd_q != CMD_RELEASE;
						ctl_d.wdata.fref = rdata.fref || cmd_q == CMD_RELEASE;
					end else if (to_clock) begin
						ctl_d.raddr = start_pos;
					end
				end
			end
			S_SLOT: begin
				ctl_d.we = 1'b1;
				ctl_d.waddr = slot_q;
				ctl_d.wdata = newe;
			end
			S_CLOCK: begin
				if (rd_v_q && !clk_exhausted) begin
					if (victim) begin
						ctl_d.we = 1'b1;
						ctl_d.wdata = newe;
					end else begin
						// clear the referenced flag as the hand passes, unless the entry's TLB flag is set
						if (!rdata.ftlb) begin
							ctl_d.we = 1'b1;
							ctl_d.wdata = rdata;
							ctl_d.wdata.fref = 1'b0;
						end
						ctl_d.raddr = pos_nx;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR; size_q <= '0; cnt_q <= '0; pos_q <= '0; hand_q <= '0;
			slot_q <= '0; slot_ok_q <= 1'b0; rd_v_q <= 1'b0; cmd_q <= CMD_NONE;
			vp_q <= '0; pid_q <= '0; steps_q <= '0; res_q <= '0; rd_idx_q <= '0;
			ctl <= '0;
		end else begin
			ctl <= ctl_d;
			case (state_q)
				S_CLEAR: begin
					pos_q <= pos_q + IDX_W'(1);
					if (pos_q == IDX_W'(FRAMES-1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						cmd_q <= cmd; vp_q <= vpage; pid_q <= pid; size_q <= used;
						res_q <= '0; cnt_q <= '0; slot_ok_q <= 1'b0;
						pos_q <= '0; rd_idx_q <= '0; rd_v_q <= 1'b0;
						state_q <= (cmd == CMD_FREE) ? S_FREE : S_LOOK;
					end
				end
				S_LOOK, S_FREE: begin
					rd_v_q <= !to_clock;
					if (SIZE_W'(rd_idx_q) + SIZE_W'(1) < size_q) begin
						rd_idx_q <= rd_idx_q + IDX_W'(1);
					end
					if (rd_v_q) begin
						if (state_q == S_FREE) begin
							if (last) begin
								res_q.status <= ST_FREED;
								res_q.freed_count <= 9'(cnt_q + SIZE_W'(free_hit));
								state_q <= S_DONE;
							end else begin
								cnt_q <= cnt_q + SIZE_W'(free_hit);
								pos_q <= pos_q + IDX_W'(1);
							end
						end else if (match) begin
							res_q.frame <= 8'(pos_q);
							if (cmd_q == CMD_RELEASE) begin
								res_q.status <= ST_RELEASED;
								res_q.tlb_flag_missing <= !rdata.ftlb;
							end else begin
								res_q.status <= ST_HIT;
								res_q.paddr <= faddr(base_paddr, pos_q);
							end
							state_q <= S_DONE;
						end else if (last) begin
							if (cmd_q == CMD_RELEASE) begin
								res_q.status <= ST_NOT_FOUND;
								state_q <= S_DONE;
							end else if (slot_ok_q || !rdata.fvalid) begin
								state_q <= S_SLOT;
								if (!slot_ok_q) slot_q <= pos_q;
							end else begin
								state_q <= S_CLOCK;
								pos_q <= start_pos;
								steps_q <= '0;
							end
						end else begin
							if (!rdata.fvalid && !slot_ok_q) begin
								slot_ok_q <= 1'b1; slot_q <= pos_q;
							end
							pos_q <= pos_q + IDX_W'(1);
						end
					end
				end
				S_SLOT: begin
					res_q.status <= ST_LOAD_FREE; res_q.frame <= 8'(slot_q);
					res_q.paddr <= faddr(base_paddr, slot_q); res_q.load_request <= 1'b1;
					state_q <= S_DONE;
				end
				S_CLOCK: begin
					// one entry at a time: read, then decide and write back
					rd_v_q <= !rd_v_q;
					if (rd_v_q) begin
						if (clk_exhausted) begin
							res_q.status <= ST_NO_FRAME;
							state_q <= S_DONE;
						end else if (victim) begin
							res_q.status <= ST_LOAD_EVICT; res_q.frame <= 8'(pos_q);
							res_q.paddr <= faddr(base_paddr, pos_q);
							res_q.load_request <= 1'b1;
							res_q.evict_valid <= rdata.fvalid;
							if (rdata.fvalid) begin
								res_q.evict_vpage <= rdata.vpage;
								res_q.evict_pid <= rdata.pid;
							end
							hand_q <= pos_nx;
							state_q <= S_DONE;
						end else begin
							steps_q <= steps_q + (SIZE_W+2)'(1);
							pos_q <= pos_nx;
						end
					end
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ----- hdl/inverted_page_table_clock_core.sv -----
// Top level of the inverted page table clock core: ports, config, output register.
// Depends on iptc_pkg, iptc_seq and iptc_table_ram.
//
// channel  | dir | contents
// s_axis   | in  | tdata: cmd[1:0], vpage[21:2], pid[31:22]
// m_axis   | out | tdata: status, paddr, frame, load_request, evict_valid,
//          |     |        evict_vpage, evict_pid, tlb_flag_missing, freed_count
// cfg      | in  | 0 base_paddr, 1 table_size
//
// One command at a time: a lookup scans the entries up to a match or table_size, a free
// scans all table_size; a free frame adds a slot write, a clock search reads entry by
// entry from the hand, and no_frame is given after 3*table_size steps.
// After reset a sweep clears the 256 entries.
// A result waits in the output register; input is held off until it is taken.
module inverted_page_table_clock_core import iptc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [31:0]  s_axis_tdata,  // cmd, vpage, pid
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [87:0]  m_axis_tdata,  // status, paddr, frame, load_request, evict_valid,
	                                    // evict_vpage, evict_pid, tlb_flag_missing, freed_count
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [31:0]  cfg_wdata
);
	logic [31:0] base_q;
	logic [8:0] size_q;
	mem_ctl_t ctl;
	entry_t rdata;
	logic busy, done;
	result_t res;
	logic start;
	logic [1:0] cmd;

	assign cmd = s_axis_tdata[1:0];
	assign s_axis_tready = !busy && !(m_axis_tvalid && !m_axis_tready);
	assign start = s_axis_tvalid && s_axis_tready && cmd != CMD_NONE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0; size_q <= 9'd256;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BASE: base_q <= cfg_wdata;
				CFG_SIZE: size_q <= cfg_wdata[8:0];
				default: ;
			endcase
		end
	end

	iptc_table_ram u_ram (.clk, .ctl, .rdata);

	iptc_seq u_seq (
		.clk, .arst_n, .start, .cmd,
		.vpage(s_axis_tdata[21:2]), .pid(s_axis_tdata[31:22]),
		.base_paddr(base_q), .table_size(size_q),
		.rdata, .ctl, .busy, .done, .res
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else begin
			m_axis_tvalid <= done || (m_axis_tvalid && !m_axis_tready);
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			m_axis_tdata <= {3'b0, res.freed_count, res.tlb_flag_missing, res.evict_pid,
				res.evict_vpage, res.evict_valid, res.load_request, res.frame,
				res.paddr, res.status};
		end
	end

`ifndef ASSERT_OFF
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !s_axis_tready) else $error("input taken while busy");
	a_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("double result");
	a_load_frame: assert property (@(posedge clk) disable iff (!arst_n)
		done && res.load_request |-> res.status == ST_LOAD_FREE || res.status == ST_LOAD_EVICT)
		else $error("load without miss");
`endif
endmodule
